>>> hw/rtl/bvg_pkg.sv
// Package for the battery voltage gauge: field widths, register reset values,
// register indexes and the control/status structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package bvg_pkg;

  localparam int VOLT_W    = 21;
  localparam int GAIN_W    = 24;
  localparam int GAIN_LO_W = 12;
  localparam int STEP_W    = 16;
  localparam int HITS_W    = 8;
  localparam int PCT_W     = 7;
  localparam int AVG_SHIFT = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int DIV_STEPS = PCT_W;

  localparam logic [VOLT_W-1:0] V_MAX    = {VOLT_W{1'b1}};
  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_MIN  = 7'd1;

  localparam logic [GAIN_W-1:0] RST_VOLT_GAIN   = 24'd2962073;
  localparam logic [VOLT_W-1:0] RST_RESET_FLOOR = 21'd200000;
  localparam logic [VOLT_W-1:0] RST_LOW_LEVEL   = 21'd550000;
  localparam logic [VOLT_W-1:0] RST_EMPTY_BASE  = 21'd650000;
  localparam logic [VOLT_W-1:0] RST_FULL_SPAN   = 21'd190000;
  localparam logic [STEP_W-1:0] RST_DROP_STEP   = 16'd1000;
  localparam logic [HITS_W-1:0] RST_DROP_HITS   = 8'd5;

  typedef enum logic [2:0] {
    REG_VOLT_GAIN   = 3'd0,
    REG_RESET_FLOOR = 3'd1,
    REG_LOW_LEVEL   = 3'd2,
    REG_EMPTY_BASE  = 3'd3,
    REG_FULL_SPAN   = 3'd4,
    REG_DROP_STEP   = 3'd5,
    REG_DROP_HITS   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] volt_gain;
    logic [VOLT_W-1:0] reset_floor;
    logic [VOLT_W-1:0] low_level;
    logic [VOLT_W-1:0] empty_base;
    logic [VOLT_W-1:0] full_span;
    logic [STEP_W-1:0] drop_step;
    logic [HITS_W-1:0] drop_hits;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic avg;
    logic track;
    logic pct;
    logic div;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic result_due;
  } status_t;

endpackage

>>> hw/rtl/bvg_sample_if.sv
// Input channel of the battery voltage gauge: one ADC sample per item.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface bvg_sample_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

>>> hw/rtl/bvg_result_if.sv
// Result channel of the battery voltage gauge: average, tracked voltage, percent.
// Valid/ready handshake; widths from bvg_pkg.
`timescale 1ns / 1ps

interface bvg_result_if
  import bvg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] average_voltage;
  logic [VOLT_W-1:0] tracked_voltage_out;
  logic [PCT_W-1:0]  percent;

  modport source (output valid, output average_voltage, output tracked_voltage_out,
                  output percent, input ready);
  modport sink   (input valid, input average_voltage, input tracked_voltage_out,
                  input percent, output ready);
endinterface

>>> hw/rtl/bvg_regs.sv
// Configuration register file of the battery voltage gauge, APB-style access.
// Depends on bvg_pkg.
`timescale 1ns / 1ps

module bvg_regs
  import bvg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[ADDR_W-1:2]);
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_gain   <= RST_VOLT_GAIN;
      cfg_q.reset_floor <= RST_RESET_FLOOR;
      cfg_q.low_level   <= RST_LOW_LEVEL;
      cfg_q.empty_base  <= RST_EMPTY_BASE;
      cfg_q.full_span   <= RST_FULL_SPAN;
      cfg_q.drop_step   <= RST_DROP_STEP;
      cfg_q.drop_hits   <= RST_DROP_HITS;
    end else if (wr_en) begin
      case (idx)
        REG_VOLT_GAIN:   cfg_q.volt_gain   <= pwdata_i[GAIN_W-1:0];
        REG_RESET_FLOOR: cfg_q.reset_floor <= pwdata_i[VOLT_W-1:0];
        REG_LOW_LEVEL:   cfg_q.low_level   <= pwdata_i[VOLT_W-1:0];
        REG_EMPTY_BASE:  cfg_q.empty_base  <= pwdata_i[VOLT_W-1:0];
        REG_FULL_SPAN:   cfg_q.full_span   <= pwdata_i[VOLT_W-1:0];
        REG_DROP_STEP:   cfg_q.drop_step   <= pwdata_i[STEP_W-1:0];
        REG_DROP_HITS:   cfg_q.drop_hits   <= pwdata_i[HITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VOLT_GAIN:   prdata_o = DATA_W'(cfg_q.volt_gain);
      REG_RESET_FLOOR: prdata_o = DATA_W'(cfg_q.reset_floor);
      REG_LOW_LEVEL:   prdata_o = DATA_W'(cfg_q.low_level);
      REG_EMPTY_BASE:  prdata_o = DATA_W'(cfg_q.empty_base);
      REG_FULL_SPAN:   prdata_o = DATA_W'(cfg_q.full_span);
      REG_DROP_STEP:   prdata_o = DATA_W'(cfg_q.drop_step);
      REG_DROP_HITS:   prdata_o = DATA_W'(cfg_q.drop_hits);
      default:         prdata_o = '0;
    endcase
  end

endmodule

>>> hw/rtl/bvg_dp.sv
// Datapath of the battery voltage gauge: sample window, split multiplier,
// tracker, percent divider and output register. Depends on bvg_pkg.
`timescale 1ns / 1ps

module bvg_dp
  import bvg_pkg::*;
#(
  parameter int WINDOW_LEN     = 10,
  parameter int WARMUP_SAMPLES = 10,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [VOLT_W-1:0]      avg_o,
  output logic [VOLT_W-1:0]      trk_o,
  output logic [PCT_W-1:0]       pct_o
);

  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int PP_W    = SUM_W + GAIN_LO_W;
  localparam int PROD_W  = SUM_W + GAIN_W;
  localparam int SH_W    = PROD_W - AVG_SHIFT;
  localparam int WC_W    = $clog2(WARMUP_SAMPLES + 1);
  localparam int NUM_W   = VOLT_W + PCT_W;
  localparam int SUM_MAX = WINDOW_LEN * ((1 << SAMPLE_BITS) - 1);

  // window and warm-up
  logic [SAMPLE_BITS-1:0] win_q [WINDOW_LEN];
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [WC_W-1:0]        warm_cnt_q;
  logic                   warmed_q;

  // product and tracker
  logic [PP_W-1:0]        p_lo_q, p_hi_q;
  logic [PROD_W-1:0]      prod;
  logic [SH_W-1:0]        prod_sh;
  logic [VOLT_W-1:0]      avg_q, avg_d;
  logic [VOLT_W-1:0]      trk_q, trk_d;
  logic [HITS_W-1:0]      hit_q, hit_d, hit_inc;

  // percent
  logic [VOLT_W-1:0]      d_val;
  logic                   fix_d, fix_q;
  logic [PCT_W-1:0]       fix_val_d, fix_val_q;
  logic [NUM_W-1:0]       rem_q, dvs_q;
  logic [PCT_W-1:0]       quo_q;
  logic                   ge;

  // output register
  logic [VOLT_W-1:0]      out_avg_q, out_trk_q;
  logic [PCT_W-1:0]       out_pct_q;

  assign status_o.result_due = warmed_q || (warm_cnt_q == WC_W'(WARMUP_SAMPLES));

  assign sum_d = sum_q - SUM_W'(win_q[WINDOW_LEN-1]) + SUM_W'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= '0;
      sum_q      <= '0;
      warm_cnt_q <= '0;
      warmed_q   <= 1'b0;
    end else if (cmd_i.load) begin
      win_q[0] <= sample_i;
      for (int i = 1; i < WINDOW_LEN; i++) win_q[i] <= win_q[i-1];
      sum_q <= sum_d;
      if (!warmed_q) begin
        if (warm_cnt_q < WC_W'(WARMUP_SAMPLES)) begin
          warm_cnt_q <= warm_cnt_q + 1'b1;
        end else begin
          warm_cnt_q <= '0;
          warmed_q   <= 1'b1;
        end
      end
    end
  end

  // sum * gain, low and high 12-bit halves of the gain on separate cycles
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      p_lo_q <= PP_W'(sum_q) * PP_W'(cfg_i.volt_gain[GAIN_LO_W-1:0]);
    end
    if (cmd_i.mul_hi) begin
      p_hi_q <= PP_W'(sum_q) * PP_W'(cfg_i.volt_gain[GAIN_W-1:GAIN_LO_W]);
    end
    if (cmd_i.avg) begin
      avg_q <= avg_d;
    end
  end

  always_comb begin
    prod    = (PROD_W'(p_hi_q) << GAIN_LO_W) + PROD_W'(p_lo_q);
    prod_sh = prod[PROD_W-1:AVG_SHIFT];
    if ({{VOLT_W{1'b0}}, prod_sh} > {{SH_W{1'b0}}, V_MAX}) begin
      avg_d = V_MAX;
    end else begin
      avg_d = VOLT_W'(prod_sh);
    end
  end

  // tracker: copy below the floor, else slow fall after enough low hits
  always_comb begin
    trk_d   = trk_q;
    hit_d   = hit_q;
    hit_inc = hit_q + 1'b1;
    if (trk_q < cfg_i.reset_floor) begin
      trk_d = avg_q;
    end else if (avg_q < trk_q && (trk_q - avg_q) >= VOLT_W'(cfg_i.drop_step)) begin
      if (hit_inc == cfg_i.drop_hits) begin
        hit_d = '0;
        trk_d = trk_q - VOLT_W'(cfg_i.drop_step);
      end else begin
        hit_d = hit_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q <= '0;
      hit_q <= '0;
    end else if (cmd_i.track) begin
      trk_q <= trk_d;
      hit_q <= hit_d;
    end
  end

  // percent: fixed answers decided up front, else d*100/span by restoring steps
  always_comb begin
    d_val     = trk_q - cfg_i.empty_base;
    fix_d     = 1'b1;
    fix_val_d = PCT_FULL;
    if (trk_q < cfg_i.low_level) begin
      fix_val_d = PCT_FULL;
    end else if (trk_q < cfg_i.empty_base) begin
      fix_val_d = PCT_MIN;
    end else if (d_val > cfg_i.full_span) begin
      fix_val_d = PCT_FULL;
    end else if (cfg_i.full_span == '0) begin
      fix_val_d = PCT_MIN;
    end else begin
      fix_d = 1'b0;
    end
  end

  assign ge = rem_q >= dvs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pct) begin
      fix_q     <= fix_d;
      fix_val_q <= fix_val_d;
      rem_q     <= NUM_W'(d_val) * NUM_W'(PCT_FULL);
      dvs_q     <= NUM_W'(cfg_i.full_span) << (PCT_W - 1);
      quo_q     <= '0;
    end else if (cmd_i.div) begin
      if (ge) rem_q <= rem_q - dvs_q;
      dvs_q <= dvs_q >> 1;
      quo_q <= {quo_q[PCT_W-2:0], ge};
    end
    if (cmd_i.emit) begin
      out_avg_q <= avg_q;
      out_trk_q <= trk_q;
      if (fix_q) begin
        out_pct_q <= fix_val_q;
      end else if (quo_q == '0) begin
        out_pct_q <= PCT_MIN;
      end else begin
        out_pct_q <= quo_q;
      end
    end
  end

  assign avg_o = out_avg_q;
  assign trk_o = out_trk_q;
  assign pct_o = out_pct_q;

  a_trk_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.track && (trk_q >= cfg_i.reset_floor) |=> trk_q <= $past(trk_q))
    else $error("tracked voltage rose above the floor");

  a_hit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.track |=> $stable(hit_q))
    else $error("hit count moved outside a tracker update");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_W'(SUM_MAX))
    else $error("window sum out of range");

endmodule

>>> hw/rtl/bvg_ctrl.sv
// Controller of the battery voltage gauge: sequences load, multiply, track,
// divide and output, and owns the result valid flag. Depends on bvg_pkg.
`timescale 1ns / 1ps

module bvg_ctrl
  import bvg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_AVG,
    S_TRACK,
    S_PCT,
    S_DIV,
    S_EMIT
  } state_e;

  localparam int CNT_W = $clog2(DIV_STEPS);

  state_e           state_q;
  logic [CNT_W-1:0] div_cnt_q;
  logic             out_valid_q;
  logic             accept;
  logic             slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    cmd_o.mul_lo = (state_q == S_MUL_LO);
    cmd_o.mul_hi = (state_q == S_MUL_HI);
    cmd_o.avg    = (state_q == S_AVG);
    cmd_o.track  = (state_q == S_TRACK);
    cmd_o.pct    = (state_q == S_PCT);
    cmd_o.div    = (state_q == S_DIV);
    cmd_o.emit   = (state_q == S_EMIT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_o.emit) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && status_i.result_due) state_q <= S_MUL_LO;
        end
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: state_q <= S_AVG;
        S_AVG:    state_q <= S_TRACK;
        S_TRACK:  state_q <= S_PCT;
        S_PCT: begin
          div_cnt_q <= '0;
          state_q   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_EMIT;
          end else begin
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result valid raised outside the output step");

  a_due_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status_i.result_due |=> state_q == S_MUL_LO)
    else $error("due item did not start the multiply");

  a_warm_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !status_i.result_due |=> state_q == S_IDLE && !$rose(out_valid_q))
    else $error("warm-up item left the idle state");

endmodule

>>> hw/rtl/battery_voltage_gauge_unit.sv
// Top level of the battery voltage gauge: register file, controller, datapath.
// Depends on bvg_pkg, bvg_sample_if, bvg_result_if, bvg_regs, bvg_ctrl, bvg_dp.
`timescale 1ns / 1ps

//  channel   dir  handshake        payload
//  sample_i  in   valid/ready      raw_sample[SAMPLE_BITS]
//  result_o  out  valid/ready      average_voltage[21], tracked_voltage_out[21],
//                                  percent[7]
//  apb       in   psel/penable     paddr[5], pwdata[32] -> prdata[32], pready = 1
//
//  Steps: a warm-up sample is taken in the idle state and gives no result. A
//  result sample goes from accept to result valid through load, two multiply
//  halves, average, tracker, percent setup, 7 restoring divide steps, output.
//  Reset: asynchronous, active low; window, sum, warm-up, tracker and hit count
//  clear, registers take their reset values.
//  Stalls: the next sample is taken while a result waits in the output
//  register; the output step waits only if that register is still full.

module battery_voltage_gauge_unit
  import bvg_pkg::*;
#(
  parameter int WINDOW_LEN     = 10,
  parameter int WARMUP_SAMPLES = 10,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // streams
  bvg_sample_if.sink        sample_i,
  bvg_result_if.source      result_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // zero wait states
  assign pready = 1'b1;

  bvg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // sequencer: one item in flight, result held in the datapath output register
  bvg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bvg_dp #(
    .WINDOW_LEN     (WINDOW_LEN),
    .WARMUP_SAMPLES (WARMUP_SAMPLES),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .status_o (status),
    .sample_i (sample_i.raw_sample),
    .avg_o    (result_o.average_voltage),
    .trk_o    (result_o.tracked_voltage_out),
    .pct_o    (result_o.percent)
  );

endmodule
